### rtl/ruhdp_pkg.sv
// ----------------------------------------------------------------------------
// ruhdp_pkg
// Shared widths, types and constants of the rectangle union hull DP unit.
// ----------------------------------------------------------------------------
package ruhdp_pkg;

   localparam int XW = 30;
   localparam int VW = 60;
   localparam int BW = 64;
   localparam int PW = 94;
   localparam int MULT_STEPS = XW;
   localparam int DEF_MAX_RECTS = 1024;

   localparam logic signed [BW-1:0] F_LIM = 64'sh2000_0000_0000_0000;
   localparam logic [VW-1:0] OUT_MAX = {VW{1'b1}};

   typedef struct packed {
      logic [XW-1:0] x;
      logic [XW-1:0] y;
      logic [VW-1:0] val;
   } rect_type;

   typedef struct packed {
      logic                 start;
      logic signed [BW-1:0] a;
      logic [XW-1:0]        b;
   } mul_req_type;

endpackage

### rtl/ruhdp_mul.sv
// ----------------------------------------------------------------------------
// ruhdp_mul
// Shared shift-add multiplier: signed 64-bit by unsigned 30-bit, one bit a cycle.
// ----------------------------------------------------------------------------
module ruhdp_mul import ruhdp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  mul_req_type          req,
   output logic                 done,
   output logic signed [PW-1:0] prod
);

   localparam int CW = $clog2(MULT_STEPS + 1);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] mcand_ff, mcand_in;
   logic [XW-1:0]        mplr_ff, mplr_in;

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mplr_in  = mplr_ff;
      if (req.start) begin
         run_in   = 1'b1;
         cnt_in   = CW'(MULT_STEPS);
         acc_in   = '0;
         mcand_in = {{(PW-BW){req.a[BW-1]}}, req.a};
         mplr_in  = req.b;
      end else if (run_ff) begin
         if (mplr_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         mplr_in  = mplr_ff >> 1;
         cnt_in   = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !run_ff) else $error("multiplier started while running");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff) else $error("multiplier done while running");

endmodule

### rtl/rect_union_hull_dp_unit.sv
// ----------------------------------------------------------------------------
// rect_union_hull_dp_unit
// Rectangle union DP over a monotone convex-hull queue, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage: drive req_* and pulse start while busy is low; each such cycle takes
// one rectangle beat, one cycle per beat while loading. Rectangles past
// MAX_RECTS are dropped. A beat with req_is_last set closes the set: the unit
// raises busy, insertion-sorts the store (one memory read a cycle), then runs
// the DP. Each rectangle runs both hull tests only when the queue holds more
// than one entry, and each front pop and back pop repeats its test; every
// multiply holds the sequencer on the shared shift-add unit. When done,
// rsp_valid is high for one cycle with rsp_best_total and busy drops in that
// same cycle. There is no result for other beats. The receiver cannot stall
// the result. Reset clears the count, queue pointers and running maximum;
// the memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module rect_union_hull_dp_unit import ruhdp_pkg::*; #(
   parameter int MAX_RECTS = DEF_MAX_RECTS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [XW-1:0] req_rect_right,
   input  logic [XW-1:0] req_rect_top,
   input  logic [VW-1:0] req_rect_cost,
   input  logic          req_is_last,
   output logic          rsp_valid,
   output logic [VW-1:0] rsp_best_total
);

   localparam int AW = $clog2(MAX_RECTS + 1);
   localparam int NS = 23;

   typedef enum logic [NS-1:0] {
      S_IDLE  = 23'd1 << 0,
      S_SRD   = 23'd1 << 1,
      S_SLD   = 23'd1 << 2,
      S_SCMP  = 23'd1 << 3,
      S_SWR   = 23'd1 << 4,
      S_DINIT = 23'd1 << 5,
      S_IRD   = 23'd1 << 6,
      S_ILD   = 23'd1 << 7,
      S_FQ    = 23'd1 << 8,
      S_FA    = 23'd1 << 9,
      S_FB    = 23'd1 << 10,
      S_FBL   = 23'd1 << 11,
      S_FMW   = 23'd1 << 12,
      S_FF    = 23'd1 << 13,
      S_FFW   = 23'd1 << 14,
      S_BQ    = 23'd1 << 15,
      S_BA    = 23'd1 << 16,
      S_BB    = 23'd1 << 17,
      S_BBL   = 23'd1 << 18,
      S_BM1   = 23'd1 << 19,
      S_BM2   = 23'd1 << 20,
      S_PUSH  = 23'd1 << 21,
      S_DONE  = 23'd1 << 22
   } state_type;

   function automatic logic goes_before(rect_type p, rect_type q);
      if (p.x != q.x) begin
         return p.x < q.x;
      end
      return p.y > q.y;
   endfunction

   rect_type             rect_mem [0:MAX_RECTS];
   logic signed [BW-1:0] best_mem [0:MAX_RECTS];
   logic [AW-1:0]        q_mem [0:MAX_RECTS];

   state_type            state_ff, state_in;
   logic [AW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        n_ff, n_in;
   logic [AW-1:0]        i_ff, i_in;
   logic [AW-1:0]        j_ff, j_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [AW-1:0]        tail_ff, tail_in;
   logic [XW-1:0]        xa_ff, xa_in, xb_ff, xb_in;
   logic signed [BW-1:0] ba_ff, ba_in, bb_ff, bb_in;
   logic [XW-1:0]        xi_ff, xi_in, yi_ff, yi_in;
   logic [VW-1:0]        vi_ff, vi_in;
   rect_type             t_ff, t_in;
   logic signed [BW-1:0] f_ff, f_in;
   logic signed [PW-1:0] p1_ff, p1_in;
   logic signed [BW-1:0] max_ff, max_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]        rsp_total_ff, rsp_total_in;

   rect_type             rect_rd_ff;
   logic signed [BW-1:0] best_rd_ff;
   logic [AW-1:0]        q_rd_ff;

   logic [AW-1:0]        rect_raddr, best_raddr, q_raddr;
   logic                 rect_we, best_we, q_we;
   logic [AW-1:0]        rect_waddr, best_waddr, q_waddr;
   rect_type             rect_wdata;
   logic signed [BW-1:0] best_wdata;
   logic [AW-1:0]        q_wdata;

   mul_req_type          mreq;
   logic                 mdone;
   logic signed [PW-1:0] mprod;

   logic signed [BW-1:0] dfront;
   logic signed [65:0]   fsum;

   ruhdp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .done  (mdone),
      .prod  (mprod)
   );

   assign dfront = bb_ff - ba_ff;
   assign fsum   = {{2{ba_ff[BW-1]}}, ba_ff} + mprod[65:0] - {6'b0, vi_ff};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      xa_in        = xa_ff;
      xb_in        = xb_ff;
      ba_in        = ba_ff;
      bb_in        = bb_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      vi_in        = vi_ff;
      t_in         = t_ff;
      f_in         = f_ff;
      p1_in        = p1_ff;
      max_in       = max_ff;
      rsp_valid_in = 1'b0;
      rsp_total_in = rsp_total_ff;
      rect_raddr   = '0;
      best_raddr   = '0;
      q_raddr      = '0;
      rect_we      = 1'b0;
      best_we      = 1'b0;
      q_we         = 1'b0;
      rect_waddr   = '0;
      best_waddr   = '0;
      q_waddr      = '0;
      rect_wdata   = '0;
      best_wdata   = '0;
      q_wdata      = '0;
      mreq         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in = cnt_ff;
               if (cnt_ff < AW'(MAX_RECTS)) begin
                  cnt_in     = cnt_ff + AW'(1);
                  n_in       = cnt_ff + AW'(1);
                  rect_we    = 1'b1;
                  rect_waddr = cnt_ff + AW'(1);
                  rect_wdata = '{x: req_rect_right, y: req_rect_top, val: req_rect_cost};
               end
               if (req_is_last) begin
                  i_in     = AW'(2);
                  state_in = (n_in >= AW'(2)) ? S_SRD : S_DINIT;
               end
            end
         end
         S_SRD: begin
            rect_raddr = i_ff;
            state_in   = S_SLD;
         end
         S_SLD: begin
            t_in       = rect_rd_ff;
            j_in       = i_ff;
            rect_raddr = i_ff - AW'(1);
            state_in   = S_SCMP;
         end
         S_SCMP: begin
            state_in = S_SWR;
            if (goes_before(t_ff, rect_rd_ff)) begin
               rect_we    = 1'b1;
               rect_waddr = j_ff;
               rect_wdata = rect_rd_ff;
               j_in       = j_ff - AW'(1);
               if (j_ff > AW'(2)) begin
                  rect_raddr = j_ff - AW'(2);
                  state_in   = S_SCMP;
               end
            end
         end
         S_SWR: begin
            rect_we    = 1'b1;
            rect_waddr = j_ff;
            rect_wdata = t_ff;
            if (i_ff == n_ff) begin
               state_in = S_DINIT;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_SRD;
            end
         end
         S_DINIT: begin
            rect_we    = 1'b1;
            best_we    = 1'b1;
            q_we       = 1'b1;
            head_in    = '0;
            tail_in    = '0;
            max_in     = '0;
            i_in       = AW'(1);
            state_in   = S_IRD;
         end
         S_IRD: begin
            rect_raddr = i_ff;
            state_in   = S_ILD;
         end
         S_ILD: begin
            xi_in    = rect_rd_ff.x;
            yi_in    = rect_rd_ff.y;
            vi_in    = rect_rd_ff.val;
            state_in = S_FQ;
         end
         S_FQ: begin
            q_raddr  = head_ff;
            state_in = S_FA;
         end
         S_FA: begin
            rect_raddr = q_rd_ff;
            best_raddr = q_rd_ff;
            if (head_ff < tail_ff) begin
               q_raddr = head_ff + AW'(1);
            end
            state_in = S_FB;
         end
         S_FB: begin
            xa_in = rect_rd_ff.x;
            ba_in = best_rd_ff;
            if (head_ff < tail_ff) begin
               rect_raddr = q_rd_ff;
               best_raddr = q_rd_ff;
               state_in   = S_FBL;
            end else begin
               state_in = S_FF;
            end
         end
         S_FBL: begin
            xb_in      = rect_rd_ff.x;
            bb_in      = best_rd_ff;
            mreq.start = 1'b1;
            mreq.a     = {{(BW-XW){1'b0}}, yi_ff};
            mreq.b     = rect_rd_ff.x - xa_ff;
            state_in   = S_FMW;
         end
         S_FMW: begin
            if (mdone) begin
               if ($signed({{(PW-BW){dfront[BW-1]}}, dfront}) > mprod) begin
                  head_in  = head_ff + AW'(1);
                  state_in = S_FQ;
               end else begin
                  state_in = S_FF;
               end
            end
         end
         S_FF: begin
            mreq.start = 1'b1;
            mreq.a     = {{(BW-XW){1'b0}}, yi_ff};
            mreq.b     = xi_ff - xa_ff;
            state_in   = S_FFW;
         end
         S_FFW: begin
            if (mdone) begin
               if (fsum > $signed({{2{F_LIM[BW-1]}}, F_LIM})) begin
                  f_in = F_LIM;
               end else if (fsum < -$signed({{2{F_LIM[BW-1]}}, F_LIM})) begin
                  f_in = -F_LIM;
               end else begin
                  f_in = fsum[BW-1:0];
               end
               best_we    = 1'b1;
               best_waddr = i_ff;
               best_wdata = f_in;
               if (f_in > max_ff) begin
                  max_in = f_in;
               end
               state_in = S_BQ;
            end
         end
         S_BQ: begin
            if (head_ff < tail_ff) begin
               q_raddr  = tail_ff - AW'(1);
               state_in = S_BA;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_BA: begin
            rect_raddr = q_rd_ff;
            best_raddr = q_rd_ff;
            q_raddr    = tail_ff;
            state_in   = S_BB;
         end
         S_BB: begin
            xa_in      = rect_rd_ff.x;
            ba_in      = best_rd_ff;
            rect_raddr = q_rd_ff;
            best_raddr = q_rd_ff;
            state_in   = S_BBL;
         end
         S_BBL: begin
            xb_in      = rect_rd_ff.x;
            bb_in      = best_rd_ff;
            mreq.start = 1'b1;
            mreq.a     = best_rd_ff - ba_ff;
            mreq.b     = xi_ff - rect_rd_ff.x;
            state_in   = S_BM1;
         end
         S_BM1: begin
            if (mdone) begin
               p1_in      = mprod;
               mreq.start = 1'b1;
               mreq.a     = f_ff - bb_ff;
               mreq.b     = xb_ff - xa_ff;
               state_in   = S_BM2;
            end
         end
         S_BM2: begin
            if (mdone) begin
               if (p1_ff < mprod) begin
                  tail_in  = tail_ff - AW'(1);
                  state_in = S_BQ;
               end else begin
                  state_in = S_PUSH;
               end
            end
         end
         S_PUSH: begin
            q_we    = 1'b1;
            q_waddr = tail_ff + AW'(1);
            q_wdata = i_ff;
            tail_in = tail_ff + AW'(1);
            if (i_ff == n_ff) begin
               state_in = S_DONE;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_IRD;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_total_in = (max_ff[BW-1:VW] != '0) ? OUT_MAX : max_ff[VW-1:0];
            cnt_in       = '0;
            head_in      = '0;
            tail_in      = '0;
            max_in       = '0;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rect_we) begin
         rect_mem[rect_waddr] <= rect_wdata;
      end
      rect_rd_ff <= rect_mem[rect_raddr];
   end

   always_ff @(posedge clock) begin
      if (best_we) begin
         best_mem[best_waddr] <= best_wdata;
      end
      best_rd_ff <= best_mem[best_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_waddr] <= q_wdata;
      end
      q_rd_ff <= q_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      xa_ff        <= xa_in;
      xb_ff        <= xb_in;
      ba_ff        <= ba_in;
      bb_ff        <= bb_in;
      xi_ff        <= xi_in;
      yi_ff        <= yi_in;
      vi_ff        <= vi_in;
      t_ff         <= t_in;
      f_ff         <= f_in;
      p1_ff        <= p1_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_total = rsp_total_ff;

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("hull queue head passed tail");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= AW'(MAX_RECTS)) else $error("rectangle count beyond store");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE) && (cnt_ff == '0))
      else $error("result beat while set not closed");
   a_max_nonneg: assert property (@(posedge clock) disable iff (reset)
      !max_ff[BW-1]) else $error("running maximum negative");

endmodule
